// ===== design/cpg_pkg.sv =====
// shared constants and types of the circle pixel generator
package cpg_pkg;

  localparam int OFS_BITS = 7;
  localparam int DEC_BITS = 12;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [DEC_BITS-1:0] DEC_INIT     = 12'd3;
  localparam logic [DEC_BITS-1:0] DEC_STEP_NEG = 12'd6;
  localparam logic [DEC_BITS-1:0] DEC_STEP_POS = 12'd10;

  typedef struct packed {
    logic pixel;
    logic done;
  } job_flags_t;

  localparam int FLAG_BITS = $bits(job_flags_t);

endpackage

// ===== design/cpg_if.sv =====
// command and pixel channel interfaces
interface cpg_cmd_if #(
  parameter int COORD_BITS = 8
);
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [COORD_BITS-1:0]         centre_x;
  logic [COORD_BITS-1:0]         centre_y;
  logic [cpg_pkg::OFS_BITS-1:0]  radius;

  modport source (output valid, output opcode, output centre_x, output centre_y,
                  output radius, input ready);
  modport sink (input valid, input opcode, input centre_x, input centre_y,
                input radius, output ready);
endinterface

interface cpg_pix_if #(
  parameter int COORD_BITS = 8
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic                  point_valid;
  logic                  last_of_step;
  logic                  circle_done;

  modport source (output valid, output point_x, output point_y, output point_valid,
                  output last_of_step, output circle_done, input ready);
  modport sink (input valid, input point_x, input point_y, input point_valid,
                input last_of_step, input circle_done, output ready);
endinterface

// ===== design/cpg_front.sv =====
// command decode and midpoint circle state update
module cpg_front #(
  parameter int COORD_BITS = 8,
  parameter int JOB_BITS   = 2 * COORD_BITS + 2 * cpg_pkg::OFS_BITS + cpg_pkg::FLAG_BITS
) (
  input  logic                clk,
  input  logic                rst,
  cpg_cmd_if.sink             cmd,
  input  logic                q_full,
  output logic                q_push,
  output logic [JOB_BITS-1:0] q_wdata
);

  localparam int OB = cpg_pkg::OFS_BITS;
  localparam int DB = cpg_pkg::DEC_BITS;

  logic [COORD_BITS-1:0] centre_col;
  logic [COORD_BITS-1:0] centre_row;
  logic [OB-1:0]         offset_a;
  logic [OB-1:0]         offset_b;
  logic [DB-1:0]         decision;
  logic                  active;

  logic                  accept;
  logic                  dec_neg;
  logic [OB+1:0]         sa;
  logic [OB+1:0]         sb;
  logic [OB+1:0]         diff;
  logic                  done;
  logic [DB-1:0]         decision_next;
  cpg_pkg::job_flags_t   flags;

  assign cmd.ready = !q_full;
  assign accept    = cmd.valid && cmd.ready;

  assign dec_neg = decision[DB-1];
  assign sa      = {2'b00, offset_a} + (OB+2)'(1);
  assign sb      = dec_neg ? {2'b00, offset_b} : {2'b00, offset_b} - (OB+2)'(1);
  assign diff    = sa - {2'b00, offset_b};
  assign done    = $signed(sa) > $signed(sb);

  always_comb begin
    if (dec_neg) begin
      decision_next = decision + DB'({sa, 2'b00}) + cpg_pkg::DEC_STEP_NEG;
    end else begin
      decision_next = decision + DB'({diff[OB+1], diff, 2'b00}) + cpg_pkg::DEC_STEP_POS;
    end
  end

  always_comb begin
    flags.pixel = active;
    flags.done  = active ? done : 1'b1;
  end

  assign q_push  = accept && (cmd.opcode == cpg_pkg::OP_STEP);
  assign q_wdata = {centre_col, centre_row, offset_a, offset_b, flags};

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_col <= '0;
      centre_row <= '0;
      offset_a   <= '0;
      offset_b   <= '0;
      decision   <= '0;
      active     <= 1'b0;
    end else if (accept) begin
      if (cmd.opcode == cpg_pkg::OP_START) begin
        centre_col <= cmd.centre_x;
        centre_row <= cmd.centre_y;
        offset_a   <= '0;
        offset_b   <= cmd.radius;
        decision   <= cpg_pkg::DEC_INIT - {{(DB-OB-1){1'b0}}, cmd.radius, 1'b0};
        active     <= 1'b1;
      end else if (active) begin
        offset_a <= sa[OB-1:0];
        offset_b <= sb[OB-1:0];
        decision <= decision_next;
        if (done) begin
          active <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== design/cpg_fifo.sv =====
// small register queue between front and back
module cpg_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = count == CW'(DEPTH);
  assign empty = count == '0;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule

// ===== design/cpg_back.sv =====
// octant point expansion and output register
module cpg_back #(
  parameter int COORD_BITS = 8,
  parameter int JOB_BITS   = 2 * COORD_BITS + 2 * cpg_pkg::OFS_BITS + cpg_pkg::FLAG_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [JOB_BITS-1:0] q_rdata,
  input  logic                q_empty,
  output logic                q_pop,
  cpg_pix_if.source           pix
);

  localparam int OB = cpg_pkg::OFS_BITS;
  localparam int CB = COORD_BITS;

  logic [CB-1:0]       job_cx;
  logic [CB-1:0]       job_cy;
  logic [OB-1:0]       job_a;
  logic [OB-1:0]       job_b;
  cpg_pkg::job_flags_t job_flags;

  logic [CB-1:0] a_c;
  logic [CB-1:0] b_c;
  logic [CB-1:0] x_pa, x_ma, x_pb, x_mb;
  logic [CB-1:0] y_pa, y_ma, y_pb, y_mb;
  logic [CB-1:0] sel_x;
  logic [CB-1:0] sel_y;

  logic [2:0]    cnt;
  logic          fire;
  logic          last;

  logic          out_valid;
  logic [CB-1:0] out_x;
  logic [CB-1:0] out_y;
  logic          out_pixel;
  logic          out_last;
  logic          out_done;

  assign {job_cx, job_cy, job_a, job_b, job_flags} = q_rdata;

  assign a_c  = CB'(job_a);
  assign b_c  = CB'(job_b);
  assign x_pa = job_cx + a_c;
  assign x_ma = job_cx - a_c;
  assign x_pb = job_cx + b_c;
  assign x_mb = job_cx - b_c;
  assign y_pa = job_cy + a_c;
  assign y_ma = job_cy - a_c;
  assign y_pb = job_cy + b_c;
  assign y_mb = job_cy - b_c;

  always_comb begin
    case (cnt)
      3'd0:    begin sel_x = x_mb; sel_y = y_ma; end
      3'd1:    begin sel_x = x_pb; sel_y = y_ma; end
      3'd2:    begin sel_x = x_ma; sel_y = y_pb; end
      3'd3:    begin sel_x = x_ma; sel_y = y_mb; end
      3'd4:    begin sel_x = x_pb; sel_y = y_pa; end
      3'd5:    begin sel_x = x_pa; sel_y = y_mb; end
      3'd6:    begin sel_x = x_pa; sel_y = y_pb; end
      default: begin sel_x = x_mb; sel_y = y_pa; end
    endcase
  end

  assign fire  = !q_empty && (!out_valid || pix.ready);
  assign last  = !job_flags.pixel || (cnt == 3'd7);
  assign q_pop = fire && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        cnt       <= last ? 3'd0 : cnt + 3'd1;
        out_valid <= 1'b1;
      end else if (pix.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_x     <= job_flags.pixel ? sel_x : '0;
      out_y     <= job_flags.pixel ? sel_y : '0;
      out_pixel <= job_flags.pixel;
      out_last  <= last;
      out_done  <= job_flags.done;
    end
  end

  assign pix.valid        = out_valid;
  assign pix.point_x      = out_x;
  assign pix.point_y      = out_y;
  assign pix.point_valid  = out_pixel;
  assign pix.last_of_step = out_last;
  assign pix.circle_done  = out_done;

  a_idle_beat_closes: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_pixel |-> out_last && out_done)
    else $error("idle step beat must be last and done");

endmodule

// ===== design/circle_pixel_generator.sv =====
// circle pixel generator top level
// a start command produces no beats
// a step command is queued, and its beats leave through the output register
// the point expander emits one beat a cycle while the receiver is ready, eight per drawing step
// a step while idle yields a single beat; the command queue holds QUEUE_DEPTH pending steps
// synchronous reset clears centre, offsets, decision and queue and leaves the block idle
module circle_pixel_generator #(
  parameter int COORD_BITS  = 8,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  cpg_cmd_if.sink   cmd,
  cpg_pix_if.source pix
);

  localparam int JOB_BITS = 2 * COORD_BITS + 2 * cpg_pkg::OFS_BITS + cpg_pkg::FLAG_BITS;

  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;
  logic [JOB_BITS-1:0] q_wdata;
  logic [JOB_BITS-1:0] q_rdata;

  cpg_front #(
    .COORD_BITS (COORD_BITS),
    .JOB_BITS   (JOB_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  cpg_fifo #(
    .WIDTH (JOB_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  cpg_back #(
    .COORD_BITS (COORD_BITS),
    .JOB_BITS   (JOB_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_rdata (q_rdata),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .pix     (pix)
  );

endmodule

// ===== bench/tb_circle_pixel_generator.sv =====
// self-checking testbench for the circle pixel generator: directed table, then random circles
module tb_circle_pixel_generator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW          = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE      = 24;

  typedef struct packed {
    logic [CW-1:0] col;
    logic [CW-1:0] row;
    logic          lit;
    logic          last;
    logic          done;
  } pixel_t;

  typedef struct packed {
    logic                         op;
    logic [CW-1:0]                cx;
    logic [CW-1:0]                cy;
    logic [cpg_pkg::OFS_BITS-1:0] r;
    logic                         typed;
    pixel_t                       want;
  } plan_row_t;

  localparam pixel_t NO_PIX   = '0;
  localparam pixel_t IDLE_PIX = '{8'h00, 8'h00, 1'b0, 1'b1, 1'b1};

  localparam plan_row_t PLAN [22] = '{
    '{cpg_pkg::OP_STEP,  8'h00, 8'h00, 7'd0,   1'b1, IDLE_PIX},
    '{cpg_pkg::OP_START, 8'h80, 8'h80, 7'd0,   1'b0, NO_PIX},
    '{cpg_pkg::OP_STEP,  8'hff, 8'hff, 7'h7f,  1'b1, '{8'h80, 8'h80, 1'b1, 1'b0, 1'b1}},
    '{cpg_pkg::OP_STEP,  8'h00, 8'h00, 7'd0,   1'b1, IDLE_PIX},
    '{cpg_pkg::OP_START, 8'h00, 8'h00, 7'd127, 1'b0, NO_PIX},
    '{cpg_pkg::OP_STEP,  8'h00, 8'h00, 7'd0,   1'b0, NO_PIX},
    '{cpg_pkg::OP_STEP,  8'hff, 8'hff, 7'h7f,  1'b0, NO_PIX},
    '{cpg_pkg::OP_STEP,  8'h5a, 8'ha5, 7'h2a,  1'b0, NO_PIX},
    '{cpg_pkg::OP_START, 8'hff, 8'hff, 7'd127, 1'b0, NO_PIX},
    '{cpg_pkg::OP_STEP,  8'h00, 8'h00, 7'd0,   1'b0, NO_PIX},
    '{cpg_pkg::OP_STEP,  8'h00, 8'h00, 7'd0,   1'b0, NO_PIX},
    '{cpg_pkg::OP_START, 8'h55, 8'haa, 7'd1,   1'b0, NO_PIX},
    '{cpg_pkg::OP_STEP,  8'h00, 8'h00, 7'd0,   1'b0, NO_PIX},
    '{cpg_pkg::OP_STEP,  8'h00, 8'h00, 7'd0,   1'b1, IDLE_PIX},
    '{cpg_pkg::OP_START, 8'haa, 8'h55, 7'd2,   1'b0, NO_PIX},
    '{cpg_pkg::OP_STEP,  8'h00, 8'h00, 7'd0,   1'b0, NO_PIX},
    '{cpg_pkg::OP_STEP,  8'h00, 8'h00, 7'd0,   1'b0, NO_PIX},
    '{cpg_pkg::OP_STEP,  8'h00, 8'h00, 7'd0,   1'b1, IDLE_PIX},
    '{cpg_pkg::OP_START, 8'hff, 8'h00, 7'd0,   1'b0, NO_PIX},
    '{cpg_pkg::OP_STEP,  8'h00, 8'h00, 7'd0,   1'b1, '{8'hff, 8'h00, 1'b1, 1'b0, 1'b1}},
    '{cpg_pkg::OP_START, 8'h00, 8'hff, 7'd0,   1'b0, NO_PIX},
    '{cpg_pkg::OP_STEP,  8'h00, 8'h00, 7'd0,   1'b1, '{8'h00, 8'hff, 1'b1, 1'b0, 1'b1}}
  };

  logic clk;
  logic rst;

  cpg_cmd_if #(.COORD_BITS(CW)) cmd_bus ();
  cpg_pix_if #(.COORD_BITS(CW)) pix_bus ();

  circle_pixel_generator #(.COORD_BITS(CW)) i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .pix (pix_bus)
  );

  // circle tracker state
  logic [CW-1:0]                       circ_cx;
  logic [CW-1:0]                       circ_cy;
  logic [cpg_pkg::OFS_BITS-1:0]        span_a;
  logic [cpg_pkg::OFS_BITS-1:0]        span_b;
  logic signed [cpg_pkg::DEC_BITS-1:0] bend_err;
  logic                                drawing;

  pixel_t pending_pixels [$];
  int     fresh_from;
  int     items_sent;
  int     mismatches;
  int     send_idle_pct;
  int     recv_idle_pct;
  int     hold_req;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic void trace_command(input logic op, input logic [CW-1:0] cx,
                                        input logic [CW-1:0] cy,
                                        input logic [cpg_pkg::OFS_BITS-1:0] r);
    logic [CW-1:0] a8;
    logic [CW-1:0] b8;
    logic [CW-1:0] xs [8];
    logic [CW-1:0] ys [8];
    int            sa;
    int            sb;
    int            d;
    logic          finish;
    pixel_t        p;
    if (op == cpg_pkg::OP_START) begin
      circ_cx  = cx;
      circ_cy  = cy;
      span_a   = '0;
      span_b   = r;
      bend_err = cpg_pkg::DEC_BITS'(3 - 2 * int'(r));
      drawing  = 1'b1;
    end else if (!drawing) begin
      pending_pixels.push_back(IDLE_PIX);
    end else begin
      a8 = CW'(span_a);
      b8 = CW'(span_b);
      xs = '{circ_cx - b8, circ_cx + b8, circ_cx - a8, circ_cx - a8,
             circ_cx + b8, circ_cx + a8, circ_cx + a8, circ_cx - b8};
      ys = '{circ_cy - a8, circ_cy - a8, circ_cy + b8, circ_cy - b8,
             circ_cy + a8, circ_cy - b8, circ_cy + b8, circ_cy + a8};
      sa = int'(span_a) + 1;
      sb = int'(span_b);
      d  = bend_err;
      if (d < 0) begin
        d = d + 4 * sa + 6;
      end else begin
        d  = d + 10 + 4 * (sa - sb);
        sb = sb - 1;
      end
      finish   = (sa > sb);
      span_a   = cpg_pkg::OFS_BITS'(sa);
      span_b   = cpg_pkg::OFS_BITS'(sb);
      bend_err = cpg_pkg::DEC_BITS'(d);
      if (finish) drawing = 1'b0;
      for (int k = 0; k < 8; k++) begin
        p.col  = xs[k];
        p.row  = ys[k];
        p.lit  = 1'b1;
        p.last = (k == 7);
        p.done = finish;
        pending_pixels.push_back(p);
      end
    end
  endfunction

  task automatic send_cmd(input logic op, input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                          input logic [cpg_pkg::OFS_BITS-1:0] r);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    cmd_bus.valid    <= 1'b1;
    cmd_bus.opcode   <= op;
    cmd_bus.centre_x <= cx;
    cmd_bus.centre_y <= cy;
    cmd_bus.radius   <= r;
    do @(posedge clk); while (!cmd_bus.ready);
    fresh_from = pending_pixels.size();
    trace_command(op, cx, cy, r);
    items_sent++;
  endtask

  task automatic drain_pixels();
    cmd_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
  endtask

  task automatic send_step();
    send_cmd(cpg_pkg::OP_STEP, CW'($urandom), CW'($urandom), cpg_pkg::OFS_BITS'($urandom));
  endtask

  task automatic run_circles(input int upto);
    logic [cpg_pkg::OFS_BITS-1:0] r;
    while (items_sent < upto) begin
      if ($urandom_range(0, 9) == 0) begin
        send_cmd(1'($urandom), CW'($urandom), CW'($urandom), cpg_pkg::OFS_BITS'($urandom));
      end else begin
        if ($urandom_range(0, 11) == 0) r = cpg_pkg::OFS_BITS'($urandom_range(13, 127));
        else r = cpg_pkg::OFS_BITS'($urandom_range(0, 12));
        send_cmd(cpg_pkg::OP_START, CW'($urandom), CW'($urandom), r);
        while (drawing) begin
          if ($urandom_range(0, 19) == 0) break;
          send_step();
        end
        if ($urandom_range(0, 7) == 0) send_step();
      end
    end
  endtask

  // result side: check each accepted beat, then pick ready for the next cycle
  initial begin
    int hold_left;
    int hold_seen;
    pixel_t want;
    hold_left = 0;
    hold_seen = 0;
    pix_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pix_bus.valid && pix_bus.ready) begin
        if (pending_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected beat x=%0h y=%0h", pix_bus.point_x,
                                    pix_bus.point_y));
        end else begin
          want = pending_pixels.pop_front();
          if (pix_bus.point_x !== want.col)
            report_mismatch($sformatf("point_x %0h, want %0h", pix_bus.point_x, want.col));
          if (pix_bus.point_y !== want.row)
            report_mismatch($sformatf("point_y %0h, want %0h", pix_bus.point_y, want.row));
          if (pix_bus.point_valid !== want.lit)
            report_mismatch($sformatf("point_valid %b, want %b", pix_bus.point_valid,
                                      want.lit));
          if (pix_bus.last_of_step !== want.last)
            report_mismatch($sformatf("last_of_step %b, want %b", pix_bus.last_of_step,
                                      want.last));
          if (pix_bus.circle_done !== want.done)
            report_mismatch($sformatf("circle_done %b, want %b", pix_bus.circle_done,
                                      want.done));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      pix_bus.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((cmd_bus.valid && cmd_bus.ready) || (pix_bus.valid && pix_bus.ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_circle_pixel_generator: errors");
    $finish;
  end

  initial begin
    rst              = 1'b1;
    cmd_bus.valid    = 1'b0;
    cmd_bus.opcode   = cpg_pkg::OP_STEP;
    cmd_bus.centre_x = '0;
    cmd_bus.centre_y = '0;
    cmd_bus.radius   = '0;
    circ_cx          = '0;
    circ_cy          = '0;
    span_a           = '0;
    span_b           = '0;
    bend_err         = '0;
    drawing          = 1'b0;
    items_sent       = 0;
    mismatches       = 0;
    hold_req         = 0;
    send_idle_pct    = 18;
    recv_idle_pct    = 56;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(PLAN); i++) begin
      send_cmd(PLAN[i].op, PLAN[i].cx, PLAN[i].cy, PLAN[i].r);
      if (PLAN[i].typed) begin
        for (int k = fresh_from; k < pending_pixels.size(); k++) begin
          pending_pixels[k]      = PLAN[i].want;
          pending_pixels[k].last = (k == pending_pixels.size() - 1);
        end
      end
    end
    drain_pixels();

    // long receiver stall while commands keep coming
    hold_req++;
    run_circles(62);
    drain_pixels();

    send_idle_pct = 56;
    recv_idle_pct = 18;
    run_circles(104);
    drain_pixels();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_circles(150);
    drain_pixels();
    repeat (SETTLE) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_circle_pixel_generator: clean");
    end else begin
      $display("tb_circle_pixel_generator: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/cpg_pkg.sv
design/cpg_if.sv
design/cpg_front.sv
design/cpg_fifo.sv
design/cpg_back.sv
design/circle_pixel_generator.sv
bench/tb_circle_pixel_generator.sv
